// ===== hdl/assert_macros.svh =====
// Assertion macros used by the allocator datapath.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define BFRA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition always brings a consequence in the same cycle
`define BFRA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bfra_pkg.sv =====
// Types and constants for the best-fit range allocator.
// No dependencies.
package bfra_pkg;

   localparam int OFF_W = 10;
   localparam int CNT_W = 11;
   localparam int HANDLE_W = 64;
   localparam int INC_W = 13;
   localparam int PROD_W = OFF_W + INC_W;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_NOFIT  = 3'd1;
   localparam logic [2:0] ST_QFULL  = 3'd2;
   localparam logic [2:0] ST_TFULL  = 3'd3;
   localparam logic [2:0] ST_BADREQ = 3'd4;

   localparam logic [1:0] CSR_HEAP_SIZE = 2'd0;
   localparam logic [1:0] CSR_BASE      = 2'd1;
   localparam logic [1:0] CSR_INC       = 2'd2;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [CNT_W-1:0] length;
   } blk_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_clr;
      logic       scan_run;
      logic       alloc_commit;
      logic       handle_add;
      logic       free_push;
      logic       rel_read;
      logic       rel_commit;
      logic       status_we;
      logic [2:0] status_code;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       count_over;
      logic       range_bad;
      logic       queue_full;
      logic       queue_empty;
      logic       queue_last;
      logic       scan_done;
      logic       found;
      logic       rel_fail;
   } sts_type;

endpackage

// ===== hdl/bfra_ctrl.sv =====
// Sequencer for the allocator: decodes requests and steps the datapath.
// Depends on bfra_pkg.
module bfra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  bfra_pkg::sts_type sts,
   output bfra_pkg::cmd_type cmd
);
   import bfra_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_ASCAN, S_AUPD, S_AADD, S_RREAD, S_RSCAN, S_RMERGE, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_RESP;
            case (sts.op)
               OP_ALLOC: begin
                  if (sts.count_zero) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ST_BADREQ;
                  end else if (sts.count_over) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ST_NOFIT;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in = S_ASCAN;
                  end
               end
               OP_FREE: begin
                  if (sts.count_zero || sts.range_bad) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ST_BADREQ;
                  end else if (sts.queue_full) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ST_QFULL;
                  end else begin
                     cmd.free_push = 1'b1;
                  end
               end
               OP_RELEASE: begin
                  if (!sts.queue_empty) begin
                     state_in = S_RREAD;
                  end
               end
               default: begin
                  cmd.status_we = 1'b1;
                  cmd.status_code = ST_BADREQ;
               end
            endcase
         end
         S_ASCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               if (sts.found) begin
                  state_in = S_AUPD;
               end else begin
                  cmd.status_we = 1'b1;
                  cmd.status_code = ST_NOFIT;
                  state_in = S_RESP;
               end
            end
         end
         S_AUPD: begin
            cmd.alloc_commit = 1'b1;
            state_in = S_AADD;
         end
         S_AADD: begin
            cmd.handle_add = 1'b1;
            state_in = S_RESP;
         end
         S_RREAD: begin
            cmd.rel_read = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in = S_RSCAN;
         end
         S_RSCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = S_RMERGE;
            end
         end
         S_RMERGE: begin
            if (sts.rel_fail) begin
               cmd.status_we = 1'b1;
               cmd.status_code = ST_TFULL;
               state_in = S_RESP;
            end else begin
               cmd.rel_commit = 1'b1;
               state_in = sts.queue_last ? S_RESP : S_RREAD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/bfra_dp.sv =====
// Datapath for the allocator: free table, stale queue, scan and merge logic.
// Depends on bfra_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bfra_dp #(
   parameter int HEAP_CAPACITY   = 1024,
   parameter int MAX_FREE_BLOCKS = 64,
   parameter int STALE_DEPTH     = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [bfra_pkg::HANDLE_W-1:0]  csr_wdata,
   input  logic [1:0]                     req_operation,
   input  logic [bfra_pkg::CNT_W-1:0]     req_count,
   input  logic [bfra_pkg::OFF_W-1:0]     req_offset,
   input  bfra_pkg::cmd_type              cmd,
   output bfra_pkg::sts_type              sts,
   output logic [2:0]                     rsp_status,
   output logic [bfra_pkg::OFF_W-1:0]     rsp_offset_res,
   output logic [bfra_pkg::HANDLE_W-1:0]  rsp_handle,
   output logic [bfra_pkg::CNT_W-1:0]     rsp_free_count
);
   import bfra_pkg::*;

   localparam int N   = MAX_FREE_BLOCKS;
   localparam int BW  = $clog2(N);
   localparam int SD  = STALE_DEPTH;
   localparam int HW  = (SD > 1) ? $clog2(SD) : 1;
   localparam int FW  = $clog2(SD + 1);
   localparam logic [CNT_W-1:0] CAP11 =
      (HEAP_CAPACITY > 2047) ? 11'd2047 : CNT_W'(HEAP_CAPACITY);
   localparam logic [CNT_W-1:0] RST_HEAP = (CAP11 < 11'd1024) ? CAP11 : 11'd1024;
   localparam logic [BW:0]   N_CNT  = (BW+1)'(N);
   localparam logic [FW:0]   SD_SUM = (FW+1)'(SD);
   localparam logic [FW-1:0] SD_FILL = FW'(SD);

   // configuration
   logic [CNT_W-1:0]    heap_ff, heap_in;
   logic [HANDLE_W-1:0] base_ff;
   logic [INC_W-1:0]    inc_ff;
   logic [CNT_W-1:0]    csr_heap;
   logic                heap_wr;

   // request and result
   logic [1:0]          op_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [OFF_W-1:0]    off_ff;
   logic [2:0]          status_ff;
   logic [OFF_W-1:0]    res_off_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [2:0]          rsp_status_ff;
   logic [OFF_W-1:0]    rsp_off_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [CNT_W-1:0]    rsp_free_ff;

   // free table
   blk_type             blk_mem [N];
   logic                mem_we;
   logic [BW-1:0]       mem_wa;
   blk_type             mem_wd;
   blk_type             rd_ff;
   logic [N-1:0]        valid_ff, valid_in;
   logic [CNT_W-1:0]    free_ff, free_in;

   // scan
   logic [BW:0]         scan_cnt_ff;
   logic                eval_vld_ff;
   logic [BW-1:0]       eval_idx_ff;
   logic                eval_hit;
   logic                best_found_ff;
   logic [BW-1:0]       best_idx_ff;
   blk_type             best_ff;
   logic                prev_found_ff, next_found_ff;
   logic [BW-1:0]       prev_idx_ff, next_idx_ff;
   blk_type             prev_ff, next_ff;

   // stale queue
   blk_type             stale_mem [SD];
   blk_type             stale_rd_ff;
   logic [HW-1:0]       head_ff, head_next;
   logic [FW-1:0]       fill_ff;
   logic [FW:0]         tail_sum;
   logic [HW-1:0]       tail;

   // merge
   logic                pm, nm;
   logic [N-1:0]        valid_clr, valid_mod;
   logic [BW-1:0]       slot;
   logic                slot_found;
   blk_type             merged;
   logic [CNT_W:0]      free_sum;

   assign csr_heap = (csr_wdata[CNT_W-1:0] > CAP11) ? CAP11 : csr_wdata[CNT_W-1:0];
   assign heap_wr = csr_we && (csr_index == CSR_HEAP_SIZE);
   assign heap_in = reset ? RST_HEAP : csr_heap;

   assign eval_hit = eval_vld_ff && valid_ff[eval_idx_ff];

   assign tail_sum = (FW+1)'(head_ff) + (FW+1)'(fill_ff);
   assign tail = (tail_sum >= SD_SUM) ? HW'(tail_sum - SD_SUM) : HW'(tail_sum);
   assign head_next = ((FW+1)'(head_ff) + (FW+1)'(1) == SD_SUM) ? '0 : head_ff + HW'(1);

   always_comb begin
      pm = prev_found_ff &&
           (({2'b0, prev_ff.start} + {1'b0, prev_ff.length}) == {2'b0, stale_rd_ff.start});
      nm = next_found_ff &&
           (({2'b0, stale_rd_ff.start} + {1'b0, stale_rd_ff.length}) ==
            {2'b0, next_ff.start});
      valid_clr = '0;
      if (pm) begin
         valid_clr[prev_idx_ff] = 1'b1;
      end
      if (nm) begin
         valid_clr[next_idx_ff] = 1'b1;
      end
      valid_mod = valid_ff & ~valid_clr;
      slot = '0;
      slot_found = 1'b0;
      for (int i = 0; i < N; i++) begin
         if (!valid_mod[i] && !slot_found) begin
            slot = BW'(i);
            slot_found = 1'b1;
         end
      end
      merged.start = pm ? prev_ff.start : stale_rd_ff.start;
      merged.length = stale_rd_ff.length + (pm ? prev_ff.length : '0) +
                      (nm ? next_ff.length : '0);
      free_sum = {1'b0, free_ff} + {1'b0, stale_rd_ff.length};
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd.start = '0;
      mem_wd.length = heap_in;
      valid_in = valid_ff;
      free_in = free_ff;
      if (reset || heap_wr) begin
         mem_we = 1'b1;
         valid_in = '0;
         valid_in[0] = (heap_in != '0);
         free_in = heap_in;
      end else if (cmd.alloc_commit) begin
         mem_wa = best_idx_ff;
         mem_wd.start = best_ff.start + OFF_W'(count_ff);
         mem_wd.length = best_ff.length - count_ff;
         if (best_ff.length > count_ff) begin
            mem_we = 1'b1;
         end else begin
            valid_in[best_idx_ff] = 1'b0;
         end
         free_in = free_ff - count_ff;
      end else if (cmd.rel_commit) begin
         mem_we = 1'b1;
         mem_wa = slot;
         mem_wd = merged;
         valid_in = valid_mod;
         valid_in[slot] = 1'b1;
         free_in = (free_sum > {1'b0, heap_ff}) ? heap_ff : free_sum[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         blk_mem[mem_wa] <= mem_wd;
      end
      if (cmd.scan_run && (scan_cnt_ff < N_CNT)) begin
         rd_ff <= blk_mem[scan_cnt_ff[BW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.free_push) begin
         stale_mem[tail].start <= off_ff;
         stale_mem[tail].length <= count_ff;
      end
      if (cmd.rel_read) begin
         stale_rd_ff <= stale_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= RST_HEAP;
         base_ff <= '0;
         inc_ff <= INC_W'(32);
         valid_ff <= valid_in;
         free_ff <= free_in;
         head_ff <= '0;
         fill_ff <= '0;
         scan_cnt_ff <= '0;
         eval_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         free_ff <= free_in;
         if (heap_wr) begin
            heap_ff <= heap_in;
            head_ff <= '0;
            fill_ff <= '0;
         end else if (cmd.free_push) begin
            fill_ff <= fill_ff + FW'(1);
         end else if (cmd.rel_commit) begin
            head_ff <= head_next;
            fill_ff <= fill_ff - FW'(1);
         end
         if (csr_we && (csr_index == CSR_BASE)) begin
            base_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_INC)) begin
            inc_ff <= csr_wdata[INC_W-1:0];
         end
         if (cmd.scan_clr) begin
            scan_cnt_ff <= '0;
            eval_vld_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            eval_vld_ff <= (scan_cnt_ff < N_CNT);
            if (scan_cnt_ff < N_CNT) begin
               scan_cnt_ff <= scan_cnt_ff + (BW+1)'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_operation;
         count_ff <= req_count;
         off_ff <= req_offset;
         status_ff <= ST_OK;
         res_off_ff <= '0;
         handle_ff <= '0;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.scan_run) begin
         eval_idx_ff <= scan_cnt_ff[BW-1:0];
      end
      if (cmd.scan_clr) begin
         best_found_ff <= 1'b0;
         prev_found_ff <= 1'b0;
         next_found_ff <= 1'b0;
      end else if (cmd.scan_run && eval_hit) begin
         if ((rd_ff.length >= count_ff) &&
             (!best_found_ff || (rd_ff.length < best_ff.length) ||
              ((rd_ff.length == best_ff.length) && (rd_ff.start < best_ff.start)))) begin
            best_found_ff <= 1'b1;
            best_idx_ff <= eval_idx_ff;
            best_ff <= rd_ff;
         end
         if (rd_ff.start < stale_rd_ff.start) begin
            if (!prev_found_ff || (rd_ff.start > prev_ff.start)) begin
               prev_found_ff <= 1'b1;
               prev_idx_ff <= eval_idx_ff;
               prev_ff <= rd_ff;
            end
         end else if (!next_found_ff || (rd_ff.start < next_ff.start)) begin
            next_found_ff <= 1'b1;
            next_idx_ff <= eval_idx_ff;
            next_ff <= rd_ff;
         end
      end
      if (cmd.alloc_commit) begin
         res_off_ff <= best_ff.start;
         prod_ff <= PROD_W'(best_ff.start) * PROD_W'(inc_ff);
      end
      if (cmd.handle_add) begin
         handle_ff <= base_ff + HANDLE_W'(prod_ff);
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_off_ff <= res_off_ff;
         rsp_handle_ff <= handle_ff;
         rsp_free_ff <= free_ff;
      end
   end

   always_comb begin
      sts.op = op_ff;
      sts.count_zero = (count_ff == '0);
      sts.count_over = (count_ff > free_ff);
      sts.range_bad = (({2'b0, off_ff} + {1'b0, count_ff}) > {1'b0, heap_ff});
      sts.queue_full = (fill_ff == SD_FILL);
      sts.queue_empty = (fill_ff == '0);
      sts.queue_last = (fill_ff == FW'(1));
      sts.scan_done = (scan_cnt_ff == N_CNT) && !eval_vld_ff;
      sts.found = best_found_ff;
      sts.rel_fail = !slot_found;
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_offset_res = rsp_off_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_free_count = rsp_free_ff;

   `BFRA_ASSERT(a_fill_bound, fill_ff <= SD_FILL, "stale queue overfilled")
   `BFRA_ASSERT(a_free_bound, free_ff <= heap_ff, "free total above heap size")
   `BFRA_ASSERT(a_commit_slot, cmd.rel_commit |-> slot_found, "merge commit without a slot")

endmodule

// ===== hdl/best_fit_range_allocator.sv =====
// Best-fit range allocator: one request at a time, one response per request.
// An allocate that passes its checks scans the whole free table through the single read port;
// free and bad requests respond without a scan; a release scans the table once for each
// queued range visited. The next request can be taken in the cycle after the response is
// loaded. Synchronous active-high reset restores heap size min(HEAP_CAPACITY, 1024), base 0,
// increment 32 and a single free block; no clearing pass is needed.
module best_fit_range_allocator #(
   parameter int HEAP_CAPACITY   = 1024,
   parameter int MAX_FREE_BLOCKS = 64,
   parameter int STALE_DEPTH     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // operation[1:0], count[12:2], offset[22:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // status[2:0], offset_res[12:3], handle[76:13],
                                    // free_count[87:77]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import bfra_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [2:0]          status;
   logic [OFF_W-1:0]    offset_res;
   logic [HANDLE_W-1:0] handle;
   logic [CNT_W-1:0]    free_count;

   bfra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bfra_dp #(
      .HEAP_CAPACITY   (HEAP_CAPACITY),
      .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
      .STALE_DEPTH     (STALE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_operation  (req_tdata[1:0]),
      .req_count      (req_tdata[12:2]),
      .req_offset     (req_tdata[22:13]),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_status     (status),
      .rsp_offset_res (offset_res),
      .rsp_handle     (handle),
      .rsp_free_count (free_count)
   );

   assign rsp_tdata = {free_count, handle, offset_res, status};

endmodule
